// ===== rtl/recursive_smoothing_dc_remover_top_assert.svh =====
// ----------------------------------------------------------------------------
// recursive smoothing dc remover assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_SMOOTHING_DC_REMOVER_TOP_ASSERT_SVH
`define RECURSIVE_SMOOTHING_DC_REMOVER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RSDCR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RSDCR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsdcr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsdcr_pkg
// shared widths, register indexes, reset values and types
// ----------------------------------------------------------------------------
`default_nettype none

package rsdcr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WIN_W       = 9;
    localparam int RATE_W      = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DC_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AC_WINDOW = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE      = 2'd2;

    // register reset values
    localparam logic [WIN_W-1:0]  DC_WINDOW_RST = 9'd64;
    localparam logic [WIN_W-1:0]  AC_WINDOW_RST = 9'd8;
    localparam logic [RATE_W-1:0] RATE_RST      = 12'd1;

    // startup sample counter
    localparam int                 COUNT_W         = 9;
    localparam logic [COUNT_W-1:0] STARTUP_SAMPLES = 9'd500;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [WIN_W-1:0]  dc_window;
        logic [WIN_W-1:0]  ac_window;
        logic [RATE_W-1:0] rate;
    } cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                startup;
    } item_t;

endpackage

`default_nettype wire

// ===== rtl/rsdcr_front.sv =====
// ----------------------------------------------------------------------------
// rsdcr_front
// accepts input words, counts samples and tags the startup period
// ----------------------------------------------------------------------------
`default_nettype none

module rsdcr_front
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [rsdcr_pkg::SAMPLE_W-1:0]        sample,
    input  wire logic                                  q_full,
    output logic                                       push,
    output rsdcr_pkg::item_t                           push_item
);

    logic [rsdcr_pkg::COUNT_W-1:0] count_reg;
    logic [rsdcr_pkg::COUNT_W-1:0] count_next;
    logic [rsdcr_pkg::COUNT_W-1:0] count_inc;

    // accept whenever the queue has room
    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // saturating sample count, this word included
    assign count_inc = (count_reg < rsdcr_pkg::STARTUP_SAMPLES)
                     ? count_reg + rsdcr_pkg::COUNT_W'(1) : count_reg;
    assign count_next = push ? count_inc : count_reg;

    // classify the word
    always_comb
    begin
        push_item.sample  = sample;
        push_item.startup = (count_inc < rsdcr_pkg::STARTUP_SAMPLES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsdcr_queue.sv =====
// ----------------------------------------------------------------------------
// rsdcr_queue
// short fifo decoupling the front from the back
// ----------------------------------------------------------------------------
`default_nettype none

module rsdcr_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire rsdcr_pkg::item_t  push_item,
    input  wire logic              pop,
    output rsdcr_pkg::item_t       head_item,
    output logic                   full,
    output logic                   empty
);

    localparam logic [rsdcr_pkg::QPTR_W-1:0] LAST_PTR =
        rsdcr_pkg::QPTR_W'(rsdcr_pkg::QUEUE_DEPTH - 1);
    localparam logic [rsdcr_pkg::QCNT_W-1:0] FULL_CNT =
        rsdcr_pkg::QCNT_W'(rsdcr_pkg::QUEUE_DEPTH);

    rsdcr_pkg::item_t                 slot_reg [rsdcr_pkg::QUEUE_DEPTH];
    logic [rsdcr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [rsdcr_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [rsdcr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [rsdcr_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [rsdcr_pkg::QCNT_W-1:0]     cnt_reg;
    logic [rsdcr_pkg::QCNT_W-1:0]     cnt_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign empty     = (cnt_reg == '0);
    assign head_item = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0
                        : wr_ptr_reg + rsdcr_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0
                        : rd_ptr_reg + rsdcr_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + rsdcr_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - rsdcr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rsdcr_div.sv =====
// ----------------------------------------------------------------------------
// rsdcr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rsdcr_div
#(
    parameter int N_W = 25,
    parameter int D_W = 12
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                done,
    output logic [N_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(N_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [D_W-1:0]    rem_reg;
    logic [D_W-1:0]    rem_next;
    logic [N_W-1:0]    quo_reg;
    logic [N_W-1:0]    quo_next;
    logic [D_W-1:0]    dsr_reg;
    logic [D_W-1:0]    dsr_next;
    logic [D_W:0]      trial;
    logic [D_W:0]      diff;
    logic              fits;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // one trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(N_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next  = {quo_reg[N_W-2:0], fits};
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

`default_nettype wire

// ===== rtl/rsdcr_back.sv =====
// ----------------------------------------------------------------------------
// rsdcr_back
// history store, window walk, averaging and pressure scaling
// ----------------------------------------------------------------------------
`default_nettype none

module rsdcr_back
#(
    parameter int HISTORY_DEPTH = 256
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire rsdcr_pkg::cfg_t                       cfg,
    input  wire logic                                  q_empty,
    input  wire rsdcr_pkg::item_t                      q_item,
    output logic                                       q_pop,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [rsdcr_pkg::SAMPLE_W-1:0]      ac_minus_dc,
    output logic        [rsdcr_pkg::SAMPLE_W-1:0]      smoothed,
    output logic signed [rsdcr_pkg::SAMPLE_W-1:0]      pressure
);

    localparam int SW      = rsdcr_pkg::SAMPLE_W;
    localparam int PTR_W   = $clog2(HISTORY_DEPTH);
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = SW + CNT_W;
    localparam int DIV_D_W = (CNT_W > rsdcr_pkg::RATE_W) ? CNT_W : rsdcr_pkg::RATE_W;

    localparam logic [PTR_W-1:0] LAST_SLOT  = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(HISTORY_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_WALK     = 3'd1;
    localparam logic [2:0] ST_DIV_GO   = 3'd2;
    localparam logic [2:0] ST_DIV_WAIT = 3'd3;
    localparam logic [2:0] ST_WB       = 3'd4;
    localparam logic [2:0] ST_OUT      = 3'd5;

    // which division the shared divider is doing
    localparam logic [1:0] DIV_AC = 2'd0;
    localparam logic [1:0] DIV_DC = 2'd1;
    localparam logic [1:0] DIV_P  = 2'd2;

    function automatic logic [CNT_W-1:0] clamp_window(input logic [rsdcr_pkg::WIN_W-1:0] w);
        logic [CNT_W-1:0] r;
        if (w == '0)
        begin
            r = CNT_W'(1);
        end
        else if (32'(w) > HISTORY_DEPTH)
        begin
            r = FULL_COUNT;
        end
        else
        begin
            r = CNT_W'(w);
        end
        return r;
    endfunction

    logic [SW-1:0]    hist_mem [HISTORY_DEPTH];

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [PTR_W-1:0] newest_reg;
    logic [PTR_W-1:0] newest_next;
    logic [PTR_W-1:0] addr_reg;
    logic [PTR_W-1:0] addr_next;
    logic [CNT_W-1:0] issue_reg;
    logic [CNT_W-1:0] issue_next;
    logic             pend_reg;
    logic             pend_next;
    logic [CNT_W-1:0] pend_idx_reg;
    logic [CNT_W-1:0] pend_idx_next;
    logic [1:0]       div_sel_reg;
    logic [1:0]       div_sel_next;
    logic             startup_reg;
    logic             startup_next;
    logic [SUM_W-1:0] ac_sum_reg;
    logic [SUM_W-1:0] ac_sum_next;
    logic [SUM_W-1:0] dc_sum_reg;
    logic [SUM_W-1:0] dc_sum_next;
    logic [SW-1:0]    ac_level_reg;
    logic [SW-1:0]    ac_level_next;
    logic [SW-1:0]    dc_level_reg;
    logic [SW-1:0]    dc_level_next;
    logic [SW-1:0]    press_reg;
    logic [SW-1:0]    press_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [SW-1:0]    amd_reg;
    logic [SW-1:0]    amd_next;
    logic [SW-1:0]    smooth_reg;
    logic [SW-1:0]    smooth_next;
    logic [SW-1:0]    pout_reg;
    logic [SW-1:0]    pout_next;

    logic [SW-1:0]    rd_data_reg;
    logic             rd_live_reg;

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    logic [SW-1:0]    mem_wdata;

    logic [CNT_W-1:0] n_ac;
    logic [CNT_W-1:0] n_dc;
    logic [CNT_W-1:0] n_max;
    logic [rsdcr_pkg::RATE_W-1:0] rate_eff;
    logic [SW-1:0]    entry_val;
    logic             sm_neg;
    logic [SW-1:0]    sm_mag;
    logic [SW-1:0]    quo_low;

    logic               div_start;
    logic [SUM_W-1:0]   div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_done;
    logic [SUM_W-1:0]   div_quotient;

    // effective window sizes and divisor
    assign n_ac     = clamp_window(cfg.ac_window);
    assign n_dc     = clamp_window(cfg.dc_window);
    assign n_max    = (n_ac > n_dc) ? n_ac : n_dc;
    assign rate_eff = (cfg.rate == '0) ? rsdcr_pkg::RATE_W'(1) : cfg.rate;

    // entries never written read as zero
    assign entry_val = rd_live_reg ? rd_data_reg : '0;

    // magnitude of the smoothed level taken as signed
    assign sm_neg  = ac_level_reg[SW-1];
    assign sm_mag  = sm_neg ? (~ac_level_reg + SW'(1)) : ac_level_reg;
    assign quo_low = div_quotient[SW-1:0];

    assign out_valid   = out_valid_reg;
    assign ac_minus_dc = amd_reg;
    assign smoothed    = smooth_reg;
    assign pressure    = pout_reg;

    // divider operand selection
    always_comb
    begin
        case (div_sel_reg)
            DIV_DC:
            begin
                div_dividend = dc_sum_reg;
                div_divisor  = DIV_D_W'(n_dc);
            end
            DIV_P:
            begin
                div_dividend = SUM_W'(sm_mag);
                div_divisor  = DIV_D_W'(rate_eff);
            end
            default:
            begin
                div_dividend = ac_sum_reg;
                div_divisor  = DIV_D_W'(n_ac);
            end
        endcase
    end

    rsdcr_div
    #(
        .N_W (SUM_W),
        .D_W (DIV_D_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        newest_next    = newest_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        div_sel_next   = div_sel_reg;
        startup_next   = startup_reg;
        ac_sum_next    = ac_sum_reg;
        dc_sum_next    = dc_sum_reg;
        ac_level_next  = ac_level_reg;
        dc_level_next  = dc_level_reg;
        press_next     = press_reg;
        out_valid_next = out_valid_reg;
        amd_next       = amd_reg;
        smooth_next    = smooth_reg;
        pout_next      = pout_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = q_item.sample;

        // result taken downstream
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    // store the raw sample and start the walk at it
                    q_pop        = 1'b1;
                    mem_we       = 1'b1;
                    newest_next  = wp_reg;
                    addr_next    = wp_reg;
                    wp_next      = (wp_reg == LAST_SLOT) ? '0 : wp_reg + PTR_W'(1);
                    fill_next    = (fill_reg == FULL_COUNT) ? fill_reg
                                 : fill_reg + CNT_W'(1);
                    startup_next = q_item.startup;
                    issue_next   = '0;
                    pend_next    = 1'b0;
                    ac_sum_next  = '0;
                    dc_sum_next  = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // accumulate the entry read last cycle
                if (pend_reg)
                begin
                    if (pend_idx_reg < n_ac)
                    begin
                        ac_sum_next = ac_sum_reg + SUM_W'(entry_val);
                    end
                    if (pend_idx_reg < n_dc)
                    begin
                        dc_sum_next = dc_sum_reg + SUM_W'(entry_val);
                    end
                end
                // issue the next older entry
                if (issue_reg != n_max)
                begin
                    addr_next     = (addr_reg == '0) ? LAST_SLOT : addr_reg - PTR_W'(1);
                    issue_next    = issue_reg + CNT_W'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        div_sel_next = DIV_AC;
                        state_next   = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (div_sel_reg)
                        DIV_AC:
                        begin
                            ac_level_next = quo_low;
                            div_sel_next  = DIV_DC;
                            state_next    = ST_DIV_GO;
                        end
                        DIV_DC:
                        begin
                            dc_level_next = quo_low;
                            div_sel_next  = DIV_P;
                            state_next    = ST_DIV_GO;
                        end
                        DIV_P:
                        begin
                            // sign back on, negatives held at zero during startup
                            if (!sm_neg)
                            begin
                                press_next = quo_low;
                            end
                            else if (startup_reg)
                            begin
                                press_next = '0;
                            end
                            else
                            begin
                                press_next = ~quo_low + SW'(1);
                            end
                            state_next = ST_WB;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WB:
            begin
                // newest entry becomes the smoothed level
                mem_we     = 1'b1;
                mem_waddr  = newest_reg;
                mem_wdata  = ac_level_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    amd_next       = ac_level_reg - dc_level_reg;
                    smooth_next    = ac_level_reg;
                    pout_next      = press_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            div_sel_reg   <= DIV_AC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            div_sel_reg   <= div_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working values and output word
    always_ff @(posedge clk)
    begin
        newest_reg   <= newest_next;
        addr_reg     <= addr_next;
        pend_idx_reg <= pend_idx_next;
        startup_reg  <= startup_next;
        ac_sum_reg   <= ac_sum_next;
        dc_sum_reg   <= dc_sum_next;
        ac_level_reg <= ac_level_next;
        dc_level_reg <= dc_level_next;
        press_reg    <= press_next;
        amd_reg      <= amd_next;
        smooth_reg   <= smooth_next;
        pout_reg     <= pout_next;
    end

    // history store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= hist_mem[addr_reg];
        rd_live_reg <= (CNT_W'(addr_reg) < fill_reg);
    end

endmodule

`default_nettype wire

// ===== rtl/recursive_smoothing_dc_remover_top.sv =====
// ----------------------------------------------------------------------------
// recursive_smoothing_dc_remover_top
// Each accepted word is one raw pressure sample. It is appended to a history
// store of HISTORY_DEPTH entries (zero after reset, tracked by a fill count),
// the newest ac_window and dc_window entries are averaged, and the newest
// entry is replaced by the smoothed average. Every sample gives one result
// word: smoothed, smoothed minus the DC average, and smoothed taken as signed
// and divided by rate (negative results read zero until 500 samples).
// An item is processed in full before the next is taken from the queue; the
// walk over the single read port of the history store and the shared
// bit-per-cycle divider set its duration. A two-word queue in front keeps the
// input accepting while the back end is busy, until the queue fills. Window
// registers are clamped to 1..HISTORY_DEPTH and a rate of zero acts as one.
// ----------------------------------------------------------------------------
`default_nettype none

module recursive_smoothing_dc_remover_top
#(
    parameter int HISTORY_DEPTH = 256
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [rsdcr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [rsdcr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [rsdcr_pkg::SAMPLE_W-1:0]        sample,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [rsdcr_pkg::SAMPLE_W-1:0]      ac_minus_dc,
    output logic        [rsdcr_pkg::SAMPLE_W-1:0]      smoothed,
    output logic signed [rsdcr_pkg::SAMPLE_W-1:0]      pressure
);

    rsdcr_pkg::cfg_t  cfg_reg;
    rsdcr_pkg::cfg_t  cfg_next;
    rsdcr_pkg::item_t push_item;
    rsdcr_pkg::item_t head_item;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                rsdcr_pkg::REG_DC_WINDOW:
                begin
                    cfg_next.dc_window = cfg_data[rsdcr_pkg::WIN_W-1:0];
                end
                rsdcr_pkg::REG_AC_WINDOW:
                begin
                    cfg_next.ac_window = cfg_data[rsdcr_pkg::WIN_W-1:0];
                end
                rsdcr_pkg::REG_RATE:
                begin
                    cfg_next.rate = cfg_data[rsdcr_pkg::RATE_W-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dc_window <= rsdcr_pkg::DC_WINDOW_RST;
            cfg_reg.ac_window <= rsdcr_pkg::AC_WINDOW_RST;
            cfg_reg.rate      <= rsdcr_pkg::RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    rsdcr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    // decoupling queue
    rsdcr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back end
    rsdcr_back
    #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_empty     (q_empty),
        .q_item      (head_item),
        .q_pop       (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ac_minus_dc (ac_minus_dc),
        .smoothed    (smoothed),
        .pressure    (pressure)
    );

endmodule

`default_nettype wire

// ===== rtl/rsdcr_chk.sv =====
// ----------------------------------------------------------------------------
// rsdcr_chk
// port-level checks on the result channel, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "recursive_smoothing_dc_remover_top_assert.svh"

module rsdcr_chk
(
    input wire logic                                  clk,
    input wire logic                                  rst_n,
    input wire logic                                  out_valid,
    input wire logic                                  out_ready,
    input wire logic signed [rsdcr_pkg::SAMPLE_W-1:0] ac_minus_dc,
    input wire logic        [rsdcr_pkg::SAMPLE_W-1:0] smoothed,
    input wire logic signed [rsdcr_pkg::SAMPLE_W-1:0] pressure
);

    // a stalled word stays offered
    `RSDCR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")

    // a stalled word keeps its payload
    `RSDCR_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(smoothed) && $stable(pressure) && $stable(ac_minus_dc), "result payload changed while stalled")

    // non-negative smoothed level never scales to a negative pressure
    `RSDCR_ASSERT_IMP(a_pos_scale, out_valid && !smoothed[15], !pressure[15], "negative pressure from non-negative level")

    // a non-zero pressure carries the sign of the smoothed level
    `RSDCR_ASSERT_IMP(a_sign_match, out_valid && (pressure != 16'sd0), pressure[15] == smoothed[15], "pressure sign differs from smoothed level")

endmodule

bind recursive_smoothing_dc_remover_top rsdcr_chk u_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ac_minus_dc (ac_minus_dc),
    .smoothed    (smoothed),
    .pressure    (pressure)
);

`default_nettype wire

// ===== dv/recursive_smoothing_dc_remover_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// recursive_smoothing_dc_remover_top_tb
// Drives raw samples into the smoothing DC remover and checks every result
// word against an in-bench history store and averaging predictor. Runs
// directed words first: field extremes, zero and oversized windows, rate of
// zero and full scale. Then random phases with fresh register settings. Both
// handshakes idle at random in several patterns. Negative smoothed levels
// are seen with the startup clamp on pressure in force.
// ----------------------------------------------------------------------------

module recursive_smoothing_dc_remover_top_tb;

    localparam int HIST_DEPTH   = 256;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RAND_PHASES  = 13;
    localparam int PHASE_WORDS  = 29;
    localparam int SETTLE_WAIT  = 400;

    typedef struct packed {
        logic signed [rsdcr_pkg::SAMPLE_W-1:0] ac_minus_dc;
        logic        [rsdcr_pkg::SAMPLE_W-1:0] smoothed;
        logic signed [rsdcr_pkg::SAMPLE_W-1:0] pressure;
    } result_t;

    // history store model and queue of expected result words
    class dc_removal_board;
        logic [rsdcr_pkg::SAMPLE_W-1:0] history [HIST_DEPTH];
        int unsigned                    wr_ptr;
        int unsigned                    seen;
        logic [rsdcr_pkg::WIN_W-1:0]    dc_win;
        logic [rsdcr_pkg::WIN_W-1:0]    ac_win;
        logic [rsdcr_pkg::RATE_W-1:0]   rate_div;
        result_t                        expected_words [$];
        int                             errors;

        function new();
            for (int i = 0; i < HIST_DEPTH; i++)
                history[i] = '0;
            wr_ptr   = 0;
            seen     = 0;
            dc_win   = rsdcr_pkg::DC_WINDOW_RST;
            ac_win   = rsdcr_pkg::AC_WINDOW_RST;
            rate_div = rsdcr_pkg::RATE_RST;
            errors   = 0;
        endfunction

        function void write_config(logic [rsdcr_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [rsdcr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                rsdcr_pkg::REG_DC_WINDOW: dc_win   = data[rsdcr_pkg::WIN_W-1:0];
                rsdcr_pkg::REG_AC_WINDOW: ac_win   = data[rsdcr_pkg::WIN_W-1:0];
                rsdcr_pkg::REG_RATE:      rate_div = data[rsdcr_pkg::RATE_W-1:0];
                default: ;
            endcase
        endfunction

        // truncated mean of the newest win entries, window clamped to the store
        function int unsigned window_mean(int unsigned newest,
                                          logic [rsdcr_pkg::WIN_W-1:0] win);
            int unsigned n;
            int unsigned sum;
            n = (win == 0) ? 1 : ((win > HIST_DEPTH) ? HIST_DEPTH : int'(win));
            sum = 0;
            for (int unsigned r = 0; r < n; r++)
                sum += history[(newest + HIST_DEPTH - r) % HIST_DEPTH];
            return sum / n;
        endfunction

        function void note_sample(logic [rsdcr_pkg::SAMPLE_W-1:0] value);
            int unsigned                    newest;
            int unsigned                    dc_level;
            int unsigned                    ac_level;
            logic [rsdcr_pkg::SAMPLE_W-1:0] ac16;
            logic [rsdcr_pkg::SAMPLE_W-1:0] dc16;
            int                             level_s;
            int                             divisor;
            int                             quot;
            result_t                        word;
            newest = wr_ptr;
            history[newest] = value;
            wr_ptr = (newest + 1) % HIST_DEPTH;
            if (seen < rsdcr_pkg::STARTUP_SAMPLES)
                seen++;
            dc_level = window_mean(newest, dc_win);
            ac_level = window_mean(newest, ac_win);
            ac16 = ac_level[rsdcr_pkg::SAMPLE_W-1:0];
            dc16 = dc_level[rsdcr_pkg::SAMPLE_W-1:0];
            // signed reading of the smoothed level, divided toward zero
            level_s = $signed(ac16);
            divisor = (rate_div == 0) ? 1 : int'(rate_div);
            quot = level_s / divisor;
            if (quot < 0 && seen < rsdcr_pkg::STARTUP_SAMPLES)
                quot = 0;
            // recursive part: newest entry becomes the smoothed level
            history[newest] = ac16;
            word.ac_minus_dc = ac16 - dc16;
            word.smoothed    = ac16;
            word.pressure    = quot[rsdcr_pkg::SAMPLE_W-1:0];
            expected_words.push_back(word);
        endfunction

        function void check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                $display("%0t unexpected result word: ac_minus_dc %0d smoothed %0d pressure %0d",
                         $time, got.ac_minus_dc, got.smoothed, got.pressure);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.ac_minus_dc !== want.ac_minus_dc)
            begin
                $display("%0t ac_minus_dc mismatch: expected %0d actual %0d",
                         $time, want.ac_minus_dc, got.ac_minus_dc);
                errors++;
            end
            if (got.smoothed !== want.smoothed)
            begin
                $display("%0t smoothed mismatch: expected %0d actual %0d",
                         $time, want.smoothed, got.smoothed);
                errors++;
            end
            if (got.pressure !== want.pressure)
            begin
                $display("%0t pressure mismatch: expected %0d actual %0d",
                         $time, want.pressure, got.pressure);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                                    clk = 1'b0;
    logic                                    rst_n = 1'b0;
    logic                                    cfg_wr_en = 1'b0;
    logic [rsdcr_pkg::CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [rsdcr_pkg::CFG_DATA_W-1:0]        cfg_data = '0;
    logic                                    in_valid = 1'b0;
    logic                                    in_ready;
    logic [rsdcr_pkg::SAMPLE_W-1:0]          sample = '0;
    logic                                    out_valid;
    logic                                    out_ready = 1'b0;
    logic signed [rsdcr_pkg::SAMPLE_W-1:0]   ac_minus_dc;
    logic        [rsdcr_pkg::SAMPLE_W-1:0]   smoothed;
    logic signed [rsdcr_pkg::SAMPLE_W-1:0]   pressure;

    dc_removal_board board;
    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              cycles = 0;

    recursive_smoothing_dc_remover_top #(
        .HISTORY_DEPTH (HIST_DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .ac_minus_dc (ac_minus_dc),
        .smoothed    (smoothed),
        .pressure    (pressure)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check accepted words, stall at random
    initial
    begin
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.ac_minus_dc = ac_minus_dc;
                got.smoothed    = smoothed;
                got.pressure    = pressure;
                board.check_word(got);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // write all three registers, one per cycle
    task automatic apply_config(input logic [rsdcr_pkg::CFG_DATA_W-1:0] dc,
                                input logic [rsdcr_pkg::CFG_DATA_W-1:0] ac,
                                input logic [rsdcr_pkg::CFG_DATA_W-1:0] rt);
        logic [rsdcr_pkg::CFG_INDEX_W-1:0] idx [3];
        logic [rsdcr_pkg::CFG_DATA_W-1:0]  val [3];
        idx[0] = rsdcr_pkg::REG_DC_WINDOW;
        idx[1] = rsdcr_pkg::REG_AC_WINDOW;
        idx[2] = rsdcr_pkg::REG_RATE;
        val[0] = dc;
        val[1] = ac;
        val[2] = rt;
        for (int i = 0; i < 3; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            board.write_config(idx[i], val[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // offer one word, with a random gap in front, until it is taken
    task automatic send_sample(input logic [rsdcr_pkg::SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_sample(value);
    endtask

    // close a phase: drop valid and wait for every result word
    task automatic finish_phase();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // idling pattern of a phase: none, sender, receiver, both
    task automatic set_idling(input int mode);
        case (mode % 4)
            0:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct = 46;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 46;
            end
            default:
            begin
                send_idle_pct = 30;
                recv_stall_pct = 30;
            end
        endcase
    endtask

    // mostly short windows, sometimes zero or beyond the store
    function automatic logic [rsdcr_pkg::CFG_DATA_W-1:0] pick_window();
        case ($urandom_range(9))
            0: return '0;
            1: return rsdcr_pkg::CFG_DATA_W'($urandom_range(256, 511));
            2: return rsdcr_pkg::CFG_DATA_W'(1);
            default: return rsdcr_pkg::CFG_DATA_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [rsdcr_pkg::CFG_DATA_W-1:0] pick_rate();
        case ($urandom_range(4))
            0: return rsdcr_pkg::CFG_DATA_W'($urandom_range(0, 1));
            1: return rsdcr_pkg::CFG_DATA_W'(4095);
            default: return rsdcr_pkg::CFG_DATA_W'($urandom_range(1, 300));
        endcase
    endfunction

    // noisy signal around a baseline, with rails and plain random words
    function automatic logic [rsdcr_pkg::SAMPLE_W-1:0] pick_sample(
        input logic [rsdcr_pkg::SAMPLE_W-1:0] baseline);
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            1, 2, 3: return rsdcr_pkg::SAMPLE_W'($urandom_range(65535));
            default: return baseline + rsdcr_pkg::SAMPLE_W'($urandom_range(511)) - 16'd256;
        endcase
    endfunction

    initial
    begin
        logic [rsdcr_pkg::SAMPLE_W-1:0] plain_words [8];
        logic [rsdcr_pkg::SAMPLE_W-1:0] clamp_words [8];
        logic [rsdcr_pkg::SAMPLE_W-1:0] wide_words [8];
        logic [rsdcr_pkg::SAMPLE_W-1:0] baseline;
        plain_words = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000,
                        16'h7FFF, 16'h0001, 16'hAAAA, 16'h5555};
        clamp_words = '{16'hFFFF, 16'h8000, 16'h0000, 16'h7FFF,
                        16'h0001, 16'hFFFE, 16'h8001, 16'h1234};
        wide_words  = '{16'h8000, 16'hFFFF, 16'h0000, 16'h7FFF,
                        16'hC000, 16'h4000, 16'hFFFF, 16'h0002};
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, empty store reads as zero
        set_idling(0);
        foreach (plain_words[i])
            send_sample(plain_words[i]);
        finish_phase();

        // zero windows and zero rate
        set_idling(2);
        apply_config('0, '0, '0);
        foreach (clamp_words[i])
            send_sample(clamp_words[i]);
        finish_phase();

        // DC window beyond the store, AC window at its size, full scale rate
        set_idling(3);
        apply_config(rsdcr_pkg::CFG_DATA_W'(511), rsdcr_pkg::CFG_DATA_W'(256),
                     rsdcr_pkg::CFG_DATA_W'(4095));
        foreach (wide_words[i])
            send_sample(wide_words[i]);
        finish_phase();

        // random phases with fresh settings
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_idling(ph);
            apply_config(pick_window(), pick_window(), pick_rate());
            baseline = rsdcr_pkg::SAMPLE_W'($urandom_range(65535));
            for (int n = 0; n < PHASE_WORDS; n++)
                send_sample(pick_sample(baseline));
            finish_phase();
        end

        repeat (SETTLE_WAIT) @(posedge clk);
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rsdcr_pkg.sv
rtl/rsdcr_front.sv
rtl/rsdcr_queue.sv
rtl/rsdcr_div.sv
rtl/rsdcr_back.sv
rtl/recursive_smoothing_dc_remover_top.sv
rtl/rsdcr_chk.sv
dv/recursive_smoothing_dc_remover_top_tb.sv
